// ===== hw/rtl/msrc_pkg.sv =====
`default_nettype none
package msrc_pkg;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  channel;
        logic [15:0] target_pos;
        logic [15:0] duration_ms;
        logic [15:0] feedback_pos;
        logic [7:0]  elapsed_ms;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [3:0]  out_channel;
        logic [15:0] compare_value;
        logic        error;
        logic        last;
    } t_out_item;

    localparam logic [1:0] MODE_STOP = 2'd0;
    localparam logic [1:0] MODE_RAMP = 2'd1;
    localparam logic [1:0] MODE_HOLD = 2'd2;

    localparam logic [1:0] CFG_PWM_MIN   = 2'd0;
    localparam logic [1:0] CFG_PWM_MAX   = 2'd1;
    localparam logic [1:0] CFG_FULL_SCL  = 2'd2;
    localparam logic [1:0] CFG_OFF_DELAY = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMD,
        ST_CHAN,
        ST_RAMP_MUL,
        ST_RAMP_GO,
        ST_RAMP_DIV,
        ST_RAMP_ADD,
        ST_SCL_MUL,
        ST_SCL_GO,
        ST_SCL_DIV,
        ST_SCL_ADD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic take_in;
        logic load_cmd;
        logic load_tick;
        logic chan_eval;
        logic ramp_mul;
        logic div_start;
        logic ramp_fin;
        logic scl_mul;
        logic scl_fin;
        logic emit;
        logic next_chan;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic zero_tick;
        logic chan_emits;
        logic chan_ramp;
        logic need_scale;
        logic div_busy;
        logic chan_last;
        logic out_full;
    } t_status;

    function automatic logic [15:0] rest_pos(input int unsigned idx);
        case (idx)
            0: rest_pos = 16'd420;
            1: rest_pos = 16'd445;
            2: rest_pos = 16'd550;
            3: rest_pos = 16'd475;
            4: rest_pos = 16'd495;
            5: rest_pos = 16'd430;
            6: rest_pos = 16'd470;
            default: rest_pos = 16'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/msrc_divider.sv =====
`default_nettype none
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
module msrc_divider
    import msrc_pkg::*;
#(
    parameter int unsigned NUM_BITS = 48,
    parameter int unsigned DEN_BITS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [NUM_BITS-1:0] i_num,
    input  wire logic [DEN_BITS-1:0] i_den,
    output logic                     o_busy,
    output logic [NUM_BITS-1:0]      o_quot
);
    localparam int unsigned CNT_BITS = $clog2(NUM_BITS + 1);

    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [NUM_BITS-1:0] r_quot, n_quot;
    logic [DEN_BITS:0]   r_rem, n_rem;
    logic [DEN_BITS-1:0] r_den, n_den;
    logic [DEN_BITS:0]   w_trial;

    always_comb begin
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_den  = r_den;
        w_trial = {r_rem[DEN_BITS-1:0], r_quot[NUM_BITS-1]};
        if (i_start) begin
            n_cnt  = CNT_BITS'(NUM_BITS);
            n_quot = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CNT_BITS'(1);
            if (w_trial >= {1'b0, r_den}) begin
                n_rem  = w_trial - {1'b0, r_den};
                n_quot = {r_quot[NUM_BITS-2:0], 1'b1};
            end else begin
                n_rem  = w_trial;
                n_quot = {r_quot[NUM_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;
endmodule
`default_nettype wire

// ===== hw/rtl/msrc_datapath.sv =====
`default_nettype none
module msrc_datapath
    import msrc_pkg::*;
#(
    parameter int unsigned CHANNELS  = 7,
    parameter int unsigned POS_BITS  = 16,
    parameter int unsigned TIME_BITS = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire t_in_item  i_item,
    input  wire t_cmd      i_cmd,
    input  wire logic      i_out_stall,
    output t_status        o_status,
    output logic           o_out_valid,
    output t_out_item      o_out_item
);
    localparam int unsigned CH_BITS  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned NUM_BITS = POS_BITS + 1 + TIME_BITS;
    localparam int unsigned DEN_BITS = (TIME_BITS > 16) ? TIME_BITS : 16;

    logic [15:0] r_pwm_min, r_pwm_max, r_fs;
    logic [7:0]  r_off_dly;
    logic [TIME_BITS-1:0] r_clock;

    logic [1:0]          r_mode  [CHANNELS];
    logic [POS_BITS-1:0] r_start [CHANNELS];
    logic [POS_BITS-1:0] r_end   [CHANNELS];
    logic [POS_BITS-1:0] r_lastp [CHANNELS];
    logic [TIME_BITS-1:0] r_begin [CHANNELS];
    logic [TIME_BITS-1:0] r_fin   [CHANNELS];

    t_in_item r_item;
    logic [CH_BITS-1:0] r_ch;
    logic [POS_BITS-1:0] r_pos;
    logic r_neg;
    logic [POS_BITS-1:0] r_mag;
    logic [TIME_BITS-1:0] r_span, r_t;
    logic [NUM_BITS-1:0] r_prod;
    logic [15:0] r_cmp;
    logic r_zero_out;
    logic r_ov;
    logic r_out_valid;
    t_out_item r_out;

    logic w_div_busy;
    logic [NUM_BITS-1:0] w_quot;

    // Per-channel decisions for the channel under evaluation.
    logic [1:0] w_mode;
    logic [TIME_BITS-1:0] w_fin, w_beg, w_span, w_t;
    logic w_done, w_hold_end, w_last_ch;
    logic [POS_BITS-1:0] w_target, w_fb;
    logic [15:0] w_clip;
    logic [15:0] w_dmag;
    logic w_dneg;
    logic w_ch_ok;
    logic w_later;

    assign w_target = r_item.target_pos[POS_BITS-1:0];
    assign w_fb     = r_item.feedback_pos[POS_BITS-1:0];
    assign w_ch_ok  = ({1'b0, r_item.channel} < 5'(CHANNELS));
    assign w_mode   = r_mode[r_ch];
    assign w_fin    = r_fin[r_ch];
    assign w_beg    = r_begin[r_ch];
    assign w_span   = w_fin - w_beg;
    assign w_t      = r_clock - w_beg;
    assign w_done   = (w_fin <= r_clock);
    assign w_hold_end = (w_fin < r_clock);
    assign w_last_ch  = (r_ch == CH_BITS'(CHANNELS - 1));
    assign w_clip   = (16'(r_pos) > r_fs) ? r_fs : 16'(r_pos);
    assign w_dneg   = (r_pwm_max < r_pwm_min);
    assign w_dmag   = w_dneg ? (r_pwm_min - r_pwm_max) : (r_pwm_max - r_pwm_min);

    // A channel still to be swept produces a result when it is ramping or its
    // hold has run out; only its own evaluation changes that, so the final
    // result of a sweep is known as soon as no such channel follows.
    always_comb begin
        w_later = 1'b0;
        for (int j = 0; j < CHANNELS; j++) begin
            if ((CH_BITS'(j) > r_ch) && ((r_mode[j] == MODE_RAMP) ||
                (r_mode[j] == MODE_HOLD && r_fin[j] < r_clock))) begin
                w_later = 1'b1;
            end
        end
    end

    msrc_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (r_prod),
        .i_den  (r_ov ? DEN_BITS'(r_fs) : DEN_BITS'(r_span)),
        .o_busy (w_div_busy),
        .o_quot (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_min <= 16'd400;
            r_pwm_max <= 16'd5600;
            r_fs      <= 16'd1000;
            r_off_dly <= 8'd50;
            r_clock   <= '0;
            r_out_valid <= 1'b0;
            r_ch      <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_mode[i]  <= MODE_STOP;
                r_start[i] <= '0;
                r_end[i]   <= '0;
                r_lastp[i] <= POS_BITS'(rest_pos(i));
                r_begin[i] <= '0;
                r_fin[i]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PWM_MIN:   r_pwm_min <= i_cfg_data;
                    CFG_PWM_MAX:   r_pwm_max <= i_cfg_data;
                    CFG_FULL_SCL:  r_fs      <= i_cfg_data;
                    CFG_OFF_DELAY: r_off_dly <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.load_cmd || i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load_cmd) begin
                if (w_ch_ok) begin
                    r_start[r_item.channel[CH_BITS-1:0]] <=
                        (w_fb != '0) ? w_fb : r_lastp[r_item.channel[CH_BITS-1:0]];
                    r_end[r_item.channel[CH_BITS-1:0]]   <= w_target;
                    r_begin[r_item.channel[CH_BITS-1:0]] <= r_clock;
                    r_fin[r_item.channel[CH_BITS-1:0]]   <=
                        r_clock + TIME_BITS'(r_item.duration_ms);
                    r_mode[r_item.channel[CH_BITS-1:0]]  <= MODE_RAMP;
                end
                r_out.result_kind   <= 1'b0;
                r_out.out_channel   <= r_item.channel;
                r_out.compare_value <= '0;
                r_out.error         <= !w_ch_ok;
                r_out.last          <= 1'b1;
            end else if (i_cmd.emit) begin
                r_out.result_kind   <= 1'b1;
                r_out.out_channel   <= 4'(r_ch);
                r_out.compare_value <= r_zero_out ? 16'd0 : r_cmp;
                r_out.error         <= 1'b0;
                r_out.last          <= !w_later;
            end
            if (i_cmd.load_tick) begin
                r_clock <= r_clock + TIME_BITS'(r_item.elapsed_ms);
                r_ch    <= '0;
            end else if (i_cmd.next_chan) begin
                r_ch <= r_ch + CH_BITS'(1);
            end
            if (i_cmd.chan_eval) begin
                r_zero_out <= 1'b0;
                if (w_mode == MODE_RAMP) begin
                    if (w_done) begin
                        r_lastp[r_ch] <= r_end[r_ch];
                        r_fin[r_ch]   <= w_fin + TIME_BITS'(r_off_dly);
                        r_mode[r_ch]  <= MODE_HOLD;
                        r_pos         <= r_end[r_ch];
                    end else if (w_span == '0) begin
                        r_pos <= r_end[r_ch];
                        r_lastp[r_ch] <= r_end[r_ch];
                    end else begin
                        r_span <= w_span;
                        r_t    <= (w_t > w_span) ? w_span : w_t;
                        r_neg  <= (r_end[r_ch] < r_start[r_ch]);
                        r_mag  <= (r_end[r_ch] < r_start[r_ch]) ?
                                  (r_start[r_ch] - r_end[r_ch]) :
                                  (r_end[r_ch] - r_start[r_ch]);
                    end
                end else if (w_mode == MODE_HOLD && w_hold_end) begin
                    r_mode[r_ch] <= MODE_STOP;
                    r_zero_out   <= 1'b1;
                end
            end
            if (i_cmd.ramp_mul) begin
                r_prod <= NUM_BITS'(r_mag) * NUM_BITS'(r_t);
                r_ov   <= 1'b0;
            end
            if (i_cmd.ramp_fin) begin
                r_pos <= r_neg ? (r_start[r_ch] - POS_BITS'(w_quot))
                               : (r_start[r_ch] + POS_BITS'(w_quot));
                r_lastp[r_ch] <= r_neg ? (r_start[r_ch] - POS_BITS'(w_quot))
                                       : (r_start[r_ch] + POS_BITS'(w_quot));
            end
            if (i_cmd.scl_mul) begin
                r_prod <= NUM_BITS'(w_dmag) * NUM_BITS'(w_clip);
                r_neg  <= w_dneg;
                r_ov   <= 1'b1;
            end
            if (i_cmd.scl_fin) begin
                if (r_pos == '0) begin
                    r_cmp <= '0;
                end else if (r_fs == '0) begin
                    r_cmp <= r_pwm_min;
                end else begin
                    r_cmp <= r_neg ? (r_pwm_min - 16'(w_quot)) : (r_pwm_min + 16'(w_quot));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_item <= i_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign o_status.is_tick    = r_item.req_type;
    assign o_status.zero_tick  = (r_item.elapsed_ms == 8'd0);
    assign o_status.chan_emits = (w_mode == MODE_RAMP) ||
                                 (w_mode == MODE_HOLD && w_hold_end);
    assign o_status.chan_ramp  = (w_mode == MODE_RAMP) && !w_done && (w_span != '0);
    assign o_status.need_scale = (w_mode == MODE_RAMP);
    assign o_status.div_busy   = w_div_busy;
    assign o_status.chan_last  = w_last_ch;
    assign o_status.out_full   = r_out_valid;
endmodule
`default_nettype wire

// ===== hw/rtl/msrc_ctrl.sv =====
`default_nettype none
module msrc_ctrl
    import msrc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output logic         o_in_stall,
    output t_cmd         o_cmd
);
    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     n_state = i_in_valid ? ST_CMD : ST_IDLE;
            ST_CMD:      n_state = !i_status.is_tick ? (i_status.out_full ? ST_CMD : ST_IDLE)
                                 : (i_status.zero_tick ? ST_IDLE : ST_CHAN);
            ST_CHAN:     n_state = !i_status.chan_emits ? (i_status.chan_last ? ST_IDLE : ST_CHAN)
                                 : (i_status.chan_ramp ? ST_RAMP_MUL :
                                    (i_status.need_scale ? ST_SCL_MUL : ST_EMIT));
            ST_RAMP_MUL: n_state = ST_RAMP_GO;
            ST_RAMP_GO:  n_state = ST_RAMP_DIV;
            ST_RAMP_DIV: n_state = i_status.div_busy ? ST_RAMP_DIV : ST_RAMP_ADD;
            ST_RAMP_ADD: n_state = ST_SCL_MUL;
            ST_SCL_MUL:  n_state = ST_SCL_GO;
            ST_SCL_GO:   n_state = ST_SCL_DIV;
            ST_SCL_DIV:  n_state = i_status.div_busy ? ST_SCL_DIV : ST_SCL_ADD;
            ST_SCL_ADD:  n_state = ST_EMIT;
            ST_EMIT:     n_state = i_status.out_full ? ST_EMIT
                                 : (i_status.chan_last ? ST_IDLE : ST_CHAN);
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_stall = !i_rst_n || (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE:     o_cmd.take_in = i_in_valid && i_rst_n;
            ST_CMD:      begin
                o_cmd.load_cmd  = !i_status.is_tick && !i_status.out_full;
                o_cmd.load_tick = i_status.is_tick && !i_status.zero_tick;
            end
            ST_CHAN:     begin
                o_cmd.chan_eval = 1'b1;
                o_cmd.next_chan = !i_status.chan_emits && !i_status.chan_last;
            end
            ST_RAMP_MUL: o_cmd.ramp_mul = 1'b1;
            ST_RAMP_GO:  o_cmd.div_start = 1'b1;
            ST_RAMP_ADD: o_cmd.ramp_fin = 1'b1;
            ST_SCL_MUL:  o_cmd.scl_mul = 1'b1;
            ST_SCL_GO:   o_cmd.div_start = 1'b1;
            ST_SCL_ADD:  o_cmd.scl_fin = 1'b1;
            ST_EMIT:     begin
                o_cmd.emit      = !i_status.out_full;
                o_cmd.next_chan = !i_status.out_full && !i_status.chan_last;
            end
            default:     ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/multi_servo_ramp_controller.sv =====
`default_nettype none
// Multi-channel servo ramp controller.
// The input channel takes one transfer per request: a move command or a
// millisecond tick. A move command gives exactly one acknowledge, flagged
// with error when the channel number is out of range. A tick sweeps the
// channels in ascending order and gives one compare update for each channel
// that is ramping, reaching its target or ending its hold; the final update
// carries last. A tick of zero length gives nothing.
// Every result leaves from the output register. After a transfer the input
// stalls until the request is done. A command waits in the command state
// while the output register is full. A tick sweeps the channels; a ramping
// channel multiplies and divides twice, a channel that reaches its target or
// has an empty span once, and one ending its hold goes straight to emit; the
// shared bit-serial divider serves both the ramp and the scaling. Every
// result further waits while the output register holds.
// Reset restores the default configuration, stops every channel and loads
// the rest positions. When the receiver stalls, the pending result holds in
// the output register and the sweep waits for it. Configuration is written
// through a plain write port, by the user only while idle (not enforced).
module multi_servo_ramp_controller
    import msrc_pkg::*;
#(
    parameter int unsigned CHANNELS  = 7,
    parameter int unsigned POS_BITS  = 16,
    parameter int unsigned TIME_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    t_cmd    w_cmd;
    t_status w_status;

    msrc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_status  (w_status),
        .o_in_stall(o_in_stall),
        .o_cmd     (w_cmd)
    );

    msrc_datapath #(
        .CHANNELS (CHANNELS),
        .POS_BITS (POS_BITS),
        .TIME_BITS(TIME_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_data),
        .i_cmd      (w_cmd),
        .i_out_stall(i_out_stall),
        .o_status   (w_status),
        .o_out_valid(o_out_valid),
        .o_out_item (o_out_data)
    );
endmodule
`default_nettype wire

// ===== bench/tb.sv =====
module tb;
    import msrc_pkg::*;

    localparam int unsigned NUM_CH      = 7;
    localparam int unsigned WATCH_LIMIT = 20000;
    localparam int unsigned DRAIN_WAIT  = 600;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = CFG_PWM_MIN;
    logic [15:0] cfg_data = '0;

    multi_servo_ramp_controller u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // The clock toggles every time unit, giving a period of two.
    always #1 i_clk = ~i_clk;

    // Shadow of the configuration and per-channel state, kept in step with the
    // block as each request transfer is accepted.
    logic [15:0] sh_pwm_min, sh_pwm_max, sh_full_scale;
    logic [7:0]  sh_off_delay;
    logic [31:0] sh_clock;
    logic [1:0]  sh_mode   [NUM_CH];
    logic [15:0] sh_start  [NUM_CH];
    logic [15:0] sh_target [NUM_CH];
    logic [15:0] sh_last   [NUM_CH];
    logic [31:0] sh_begin  [NUM_CH];
    logic [31:0] sh_finish [NUM_CH];

    t_in_item  pending_reqs[$];
    t_out_item awaited_results[$];

    int unsigned fails = 0;
    int unsigned idle_cycles = 0;
    int unsigned send_idle_pct = 24;
    int unsigned recv_idle_pct = 79;
    int unsigned hold_off_left = 0;
    bit          send_paused = 1'b0;

    // Maps a position onto the compare range; zero means output off.
    function automatic logic [15:0] servo_compare(input logic [15:0] p);
        longint x, d, v;
        if (p == 16'd0) return 16'd0;
        if (sh_full_scale == 16'd0) return sh_pwm_min;
        x = (p > sh_full_scale) ? longint'(sh_full_scale) : longint'(p);
        d = longint'(sh_pwm_max) - longint'(sh_pwm_min);
        v = x * d / longint'(sh_full_scale) + longint'(sh_pwm_min);
        return v[15:0];
    endfunction

    task automatic reset_shadow();
        sh_pwm_min = 16'd400;
        sh_pwm_max = 16'd5600;
        sh_full_scale = 16'd1000;
        sh_off_delay = 8'd50;
        sh_clock = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            sh_mode[i] = MODE_STOP;
            sh_start[i] = '0;
            sh_target[i] = '0;
            sh_last[i] = rest_pos(i);
            sh_begin[i] = '0;
            sh_finish[i] = '0;
        end
    endtask

    // Works out every result that one accepted request causes.
    task automatic predict_servo(input t_in_item r);
        t_out_item res;
        int unsigned first_new;
        logic [31:0] span, t;
        logic [15:0] pos;
        longint diff;
        first_new = awaited_results.size();
        res = '0;
        if (r.req_type == 1'b0) begin
            res.out_channel = r.channel;
            res.last = 1'b1;
            if (r.channel >= NUM_CH) begin
                res.error = 1'b1;
            end else begin
                sh_start[r.channel] = (r.feedback_pos != 0) ? r.feedback_pos
                                                            : sh_last[r.channel];
                sh_target[r.channel] = r.target_pos;
                sh_begin[r.channel] = sh_clock;
                sh_finish[r.channel] = sh_clock + 32'(r.duration_ms);
                sh_mode[r.channel] = MODE_RAMP;
            end
            awaited_results.push_back(res);
            return;
        end
        if (r.elapsed_ms == 8'd0) return;
        sh_clock = sh_clock + 32'(r.elapsed_ms);
        for (int i = 0; i < NUM_CH; i++) begin
            res = '0;
            res.result_kind = 1'b1;
            res.out_channel = 4'(i);
            if (sh_mode[i] == MODE_RAMP) begin
                if (sh_finish[i] <= sh_clock) begin
                    sh_last[i] = sh_target[i];
                    sh_finish[i] = sh_finish[i] + 32'(sh_off_delay);
                    sh_mode[i] = MODE_HOLD;
                    res.compare_value = servo_compare(sh_target[i]);
                end else begin
                    span = sh_finish[i] - sh_begin[i];
                    t = sh_clock - sh_begin[i];
                    if (span == 0) begin
                        pos = sh_target[i];
                    end else begin
                        if (t > span) t = span;
                        diff = longint'(sh_target[i]) - longint'(sh_start[i]);
                        pos = 16'(longint'(sh_start[i]) + diff * longint'(t)
                                  / longint'(span));
                    end
                    sh_last[i] = pos;
                    res.compare_value = servo_compare(pos);
                end
                awaited_results.push_back(res);
            end else if (sh_mode[i] == MODE_HOLD && sh_finish[i] < sh_clock) begin
                sh_mode[i] = MODE_STOP;
                awaited_results.push_back(res);
            end
        end
        if (awaited_results.size() > first_new)
            awaited_results[awaited_results.size() - 1].last = 1'b1;
    endtask

    function automatic t_in_item move_req(input logic [3:0] ch, input logic [15:0] tgt,
                                          input logic [15:0] dur, input logic [15:0] fb);
        t_in_item r;
        r = '0;
        r.channel = ch;
        r.target_pos = tgt;
        r.duration_ms = dur;
        r.feedback_pos = fb;
        return r;
    endfunction

    function automatic t_in_item tick_req(input logic [7:0] el);
        t_in_item r;
        r = '0;
        r.req_type = 1'b1;
        r.elapsed_ms = el;
        return r;
    endfunction

    // Random request: mostly well-formed moves on valid channels and ticks,
    // with fields fully randomised so every bit of every field toggles.
    function automatic t_in_item random_req();
        t_in_item r;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        r = raw[$bits(t_in_item)-1:0];
        if ($urandom_range(99) < 55) begin
            r.req_type = 1'b1;
            r.elapsed_ms = ($urandom_range(9) == 0) ? 8'($urandom)
                                                    : 8'($urandom_range(0, 20));
        end else begin
            r.req_type = 1'b0;
            if ($urandom_range(9) != 0) r.channel = 4'($urandom_range(0, NUM_CH - 1));
            if ($urandom_range(3) != 0) r.duration_ms = 16'($urandom_range(0, 150));
            if ($urandom_range(2) == 0) r.feedback_pos = '0;
            if ($urandom_range(2) != 0) r.target_pos = 16'($urandom_range(0, 1200));
        end
        return r;
    endfunction

    // Request driver: presents the head of the queue and keeps it steady
    // while the block stalls, dropping it only once the transfer happens.
    always @(posedge i_clk) begin
        if (in_valid && !in_stall) begin
            predict_servo(in_data);
            void'(pending_reqs.pop_front());
        end
        if (in_valid && in_stall) begin
            // Held until accepted.
        end else if (pending_reqs.size() != 0 && !send_paused &&
                     $urandom_range(99) >= send_idle_pct) begin
            in_valid <= 1'b1;
            in_data  <= pending_reqs[0];
        end else begin
            in_valid <= 1'b0;
        end
    end

    // Result monitor: each accepted result is checked against the oldest
    // prediction. The stall is chosen at random, or held for a long stretch
    // while a hold-off count runs down.
    always @(posedge i_clk) begin
        t_out_item exp_res;
        if (i_rst_n && out_valid && !out_stall) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result %p", out_data);
                fails++;
            end else begin
                exp_res = awaited_results.pop_front();
                if (out_data.result_kind !== exp_res.result_kind) begin
                    $error("result_kind exp %0d got %0d", exp_res.result_kind,
                           out_data.result_kind);
                    fails++;
                end
                if (out_data.out_channel !== exp_res.out_channel) begin
                    $error("out_channel exp %0d got %0d", exp_res.out_channel,
                           out_data.out_channel);
                    fails++;
                end
                if (out_data.compare_value !== exp_res.compare_value) begin
                    $error("compare_value exp %0d got %0d", exp_res.compare_value,
                           out_data.compare_value);
                    fails++;
                end
                if (out_data.error !== exp_res.error) begin
                    $error("error exp %0d got %0d", exp_res.error, out_data.error);
                    fails++;
                end
                if (out_data.last !== exp_res.last) begin
                    $error("last exp %0d got %0d", exp_res.last, out_data.last);
                    fails++;
                end
            end
        end
        if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: counts cycles in which neither channel transfers.
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCH_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PWM_MIN:   sh_pwm_min = val;
            CFG_PWM_MAX:   sh_pwm_max = val;
            CFG_FULL_SCL:  sh_full_scale = val;
            CFG_OFF_DELAY: sh_off_delay = val[7:0];
            default: ;
        endcase
    endtask

    // Waits for the queue to empty and every prediction to be met, then
    // lets the block finish any silent work before the next step.
    task automatic drain_all();
        while (pending_reqs.size() != 0 || in_valid || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic random_phase(input int unsigned n);
        for (int k = 0; k < n; k++) pending_reqs.push_back(random_req());
    endtask

    initial begin
        reset_shadow();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: both request kinds, the channel extremes, bad
        // channels, a zero-length tick, zero duration and feedback of zero.
        pending_reqs.push_back(tick_req(8'd5));
        pending_reqs.push_back(move_req(4'd0, 16'd900, 16'd40, 16'd0));
        pending_reqs.push_back(move_req(4'd6, 16'hFFFF, 16'd0, 16'hFFFF));
        pending_reqs.push_back(move_req(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_reqs.push_back(move_req(4'd7, 16'd1, 16'd1, 16'd1));
        pending_reqs.push_back(move_req(4'd3, 16'd0, 16'd10, 16'd1000));
        pending_reqs.push_back(tick_req(8'd0));
        pending_reqs.push_back(tick_req(8'd1));
        pending_reqs.push_back(tick_req(8'd15));
        pending_reqs.push_back(move_req(4'd0, 16'd100, 16'd20, 16'd0));
        pending_reqs.push_back(tick_req(8'd30));
        pending_reqs.push_back(tick_req(8'hFF));
        pending_reqs.push_back(tick_req(8'hFF));
        drain_all();

        // Extreme settings: inverted range, zero full scale, no off-delay.
        write_reg(CFG_PWM_MIN, 16'hFFFF);
        write_reg(CFG_PWM_MAX, 16'h0000);
        write_reg(CFG_FULL_SCL, 16'h0000);
        write_reg(CFG_OFF_DELAY, 16'h0000);
        pending_reqs.push_back(move_req(4'd2, 16'd500, 16'd4, 16'd0));
        pending_reqs.push_back(tick_req(8'd2));
        pending_reqs.push_back(tick_req(8'd3));
        pending_reqs.push_back(tick_req(8'd1));
        drain_all();

        // Sender idles lightly, receiver heavily; a long hold-off fills the
        // block so that its input stalls.
        write_reg(CFG_FULL_SCL, 16'hFFFF);
        write_reg(CFG_PWM_MAX, 16'hFFFF);
        write_reg(CFG_PWM_MIN, 16'h0000);
        write_reg(CFG_OFF_DELAY, 16'h00FF);
        send_idle_pct = 24;
        recv_idle_pct = 79;
        for (int c = 0; c < NUM_CH; c++)
            pending_reqs.push_back(move_req(4'(c), 16'($urandom), 16'd50, 16'd0));
        for (int k = 0; k < 6; k++) pending_reqs.push_back(tick_req(8'd3));
        hold_off_left = 3000;
        random_phase(35);
        drain_all();

        // The roles swap; the sender pauses until everything has come back.
        write_reg(CFG_PWM_MIN, 16'd400);
        write_reg(CFG_PWM_MAX, 16'd5600);
        write_reg(CFG_FULL_SCL, 16'd1000);
        write_reg(CFG_OFF_DELAY, 16'd20);
        send_idle_pct = 79;
        recv_idle_pct = 24;
        random_phase(30);
        while (pending_reqs.size() != 0 || in_valid) @(posedge i_clk);
        send_paused = 1'b1;
        while (awaited_results.size() != 0) @(posedge i_clk);
        send_paused = 1'b0;
        random_phase(30);
        drain_all();

        // Neither side idles.
        write_reg(CFG_OFF_DELAY, 16'd5);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(45);
        drain_all();

        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/msrc_pkg.sv
hw/rtl/msrc_divider.sv
hw/rtl/msrc_datapath.sv
hw/rtl/msrc_ctrl.sv
hw/rtl/multi_servo_ramp_controller.sv
bench/tb.sv
